// ===== hw/rtl/bptc_pkg.sv =====
`default_nettype none

package bptc_pkg;

	// First-order reference temperature and very-low threshold, in 0.01 C
	localparam int TEMP_REF      = 2000;
	localparam int TEMP_VERY_LOW = 1500;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_C1     = 3'd0,
		REG_C2     = 3'd1,
		REG_C3     = 3'd2,
		REG_C4     = 3'd3,
		REG_C5     = 3'd4,
		REG_C6     = 3'd5,
		REG_SO_EN  = 3'd6
	} cfg_reg_t;

	// Calibration words and mode bit
	typedef struct packed {
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
		logic [15:0] c6;
		logic        so_en;
	} cal_t;

	// First-order results handed to the second-order section
	typedef struct packed {
		logic        [23:0] d1;
		logic signed [18:0] temp;
		logic signed [35:0] off;
		logic signed [34:0] sens;
		logic        [17:0] temp2;
	} first_t;

	// Corrected values handed to the pressure section
	typedef struct packed {
		logic        [23:0] d1;
		logic signed [18:0] temp;
		logic signed [39:0] off;
		logic signed [39:0] sens;
	} press_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bptc_in_if.sv =====
`default_nettype none

interface bptc_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] raw_pressure;
	logic [23:0] raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bptc_out_if.sv =====
`default_nettype none

interface bptc_out_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] temp_centideg;
	logic signed [31:0] pressure_pa;

	modport source (output valid, output temp_centideg, output pressure_pa, input ready);
	modport sink   (input valid, input temp_centideg, input pressure_pa, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bptc_first.sv =====
`default_nettype none

// First-order section: dT, the three dT products and dT squared, then TEMP, OFF, SENS and TEMP2.
module bptc_first (
	input  logic                clk,
	input  logic                arst_n,
	input  bptc_pkg::cal_t      cal,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [23:0]         d1,
	input  logic [23:0]         d2,
	output logic                out_valid,
	input  logic                out_ready,
	output bptc_pkg::first_t    out_data
);
	import bptc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic        [23:0] d1_s1, d1_s2;
	logic signed [24:0] dt_s1;
	logic signed [41:0] pt_s2, po_s2, ps_s2;
	logic signed [49:0] dsq_s2;
	first_t             res_s3;

	logic signed [16:0] c3_sx, c4_sx, c6_sx;
	logic signed [41:0] pt_rnd, po_rnd, ps_rnd;

	// stage enables: a stage loads when empty or when its successor moves
	assign en3      = ~v_s3 | out_ready;
	assign en2      = ~v_s2 | en3;
	assign en1      = ~v_s1 | en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	assign c3_sx = $signed({1'b0, cal.c3});
	assign c4_sx = $signed({1'b0, cal.c4});
	assign c6_sx = $signed({1'b0, cal.c6});

	// truncate-toward-zero bias for the power-of-two divides
	assign pt_rnd = pt_s2 + (pt_s2[41] ? 42'sd8388607 : 42'sd0);
	assign po_rnd = po_s2 + (po_s2[41] ? 42'sd127 : 42'sd0);
	assign ps_rnd = ps_s2 + (ps_s2[41] ? 42'sd255 : 42'sd0);

	always_ff @(posedge clk) begin
		// s1: dT = D2 - C5 * 256
		if (en1) begin
			d1_s1 <= d1;
			dt_s1 <= $signed({1'b0, d2}) - $signed({1'b0, cal.c5, 8'b0});
		end
		// s2: products of dT
		if (en2) begin
			d1_s2  <= d1_s1;
			pt_s2  <= 42'(dt_s1) * 42'(c6_sx);
			po_s2  <= 42'(dt_s1) * 42'(c4_sx);
			ps_s2  <= 42'(dt_s1) * 42'(c3_sx);
			dsq_s2 <= 50'(dt_s1) * 50'(dt_s1);
		end
		// s3: scale and offset
		if (en3) begin
			res_s3.d1    <= d1_s2;
			res_s3.temp  <= 19'(pt_rnd >>> 23) + 19'(TEMP_REF);
			res_s3.off   <= 36'(po_rnd >>> 7) + 36'($signed({1'b0, cal.c2, 16'b0}));
			res_s3.sens  <= 35'(ps_rnd >>> 8) + 35'($signed({1'b0, cal.c1, 15'b0}));
			res_s3.temp2 <= dsq_s2[48:31];
		end
	end

	assign out_valid = v_s3;
	assign out_data  = res_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/bptc_second.sv =====
`default_nettype none

// Low-temperature second-order correction of TEMP, OFF and SENS.
module bptc_second (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                so_en,
	input  logic                in_valid,
	output logic                in_ready,
	input  bptc_pkg::first_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bptc_pkg::press_t    out_data
);
	import bptc_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic en4, en5, en6;

	first_t             f_s4, f_s5;
	logic        [35:0] sq_s4, sq2_s4;
	logic               lo_s4, vlo_s4;
	logic signed [18:0] temp_s5;
	logic        [38:0] off2_s5, sens2_s5;
	press_t             res_s6;

	logic signed [18:0] a_d, b_d;
	logic        [38:0] f5, s7, e11;
	logic        [38:0] off2_d, sens2_d;

	assign en6      = ~v_s6 | out_ready;
	assign en5      = ~v_s5 | en6;
	assign en4      = ~v_s4 | en5;
	assign in_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// distances from the two thresholds
	assign a_d = in_data.temp - 19'(TEMP_REF);
	assign b_d = in_data.temp + 19'(TEMP_VERY_LOW);

	// 5*sq, 7*sq2, 11*sq2 by shift and add
	assign f5  = 39'({sq_s4, 2'b0}) + 39'(sq_s4);
	assign s7  = 39'({sq2_s4, 3'b0}) - 39'(sq2_s4);
	assign e11 = 39'({sq2_s4, 3'b0}) + 39'({sq2_s4, 1'b0}) + 39'(sq2_s4);

	always_comb begin
		off2_d  = '0;
		sens2_d = '0;
		if (lo_s4) begin
			off2_d  = (f5 >> 1) + (vlo_s4 ? s7 : 39'd0);
			sens2_d = (f5 >> 2) + (vlo_s4 ? (e11 >> 1) : 39'd0);
		end
	end

	always_ff @(posedge clk) begin
		// s4: squares and range tests on first-order TEMP
		if (en4) begin
			f_s4   <= in_data;
			sq_s4  <= 36'(36'(a_d) * 36'(a_d));
			sq2_s4 <= 36'(36'(b_d) * 36'(b_d));
			lo_s4  <= so_en & (in_data.temp < 19'(TEMP_REF));
			vlo_s4 <= in_data.temp < -19'(TEMP_VERY_LOW);
		end
		// s5: correction terms and final temperature
		if (en5) begin
			f_s5     <= f_s4;
			off2_s5  <= off2_d;
			sens2_s5 <= sens2_d;
			temp_s5  <= f_s4.temp - (lo_s4 ? $signed({1'b0, f_s4.temp2}) : 19'sd0);
		end
		// s6: apply corrections
		if (en6) begin
			res_s6.d1   <= f_s5.d1;
			res_s6.temp <= temp_s5;
			res_s6.off  <= 40'(f_s5.off) - $signed({1'b0, off2_s5});
			res_s6.sens <= 40'(f_s5.sens) - $signed({1'b0, sens2_s5});
		end
	end

	assign out_valid = v_s6;
	assign out_data  = res_s6;

endmodule

`default_nettype wire

// ===== hw/rtl/bptc_press.sv =====
`default_nettype none

// Pressure: D1*SENS in two partial products, then the two scaled divides.
module bptc_press (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bptc_pkg::press_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [18:0]  temp_out,
	output logic signed [31:0]  press_out
);
	import bptc_pkg::*;

	logic v_s7, v_s8, v_s9, v_s10;
	logic en7, en8, en9, en10;

	logic signed [18:0] t_s7, t_s8, t_s9, t_s10;
	logic signed [39:0] off_s7, off_s8;
	logic        [43:0] pl_s7;
	logic signed [44:0] ph_s7;
	logic signed [63:0] prod_s8;
	logic signed [44:0] x_s9;
	logic signed [31:0] p_s10;

	logic        [19:0] sens_lo;
	logic signed [19:0] sens_hi;
	logic signed [63:0] prod_rnd;
	logic signed [44:0] x_rnd;

	assign en10     = ~v_s10 | out_ready;
	assign en9      = ~v_s9 | en10;
	assign en8      = ~v_s8 | en9;
	assign en7      = ~v_s7 | en8;
	assign in_ready = en7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en7)  v_s7  <= in_valid;
			if (en8)  v_s8  <= v_s7;
			if (en9)  v_s9  <= v_s8;
			if (en10) v_s10 <= v_s9;
		end
	end

	// SENS split into an unsigned low part and a signed high part
	assign sens_lo = in_data.sens[19:0];
	assign sens_hi = in_data.sens[39:20];

	assign prod_rnd = prod_s8 + (prod_s8[63] ? 64'sd2097151 : 64'sd0);
	assign x_rnd    = x_s9 + (x_s9[44] ? 45'sd32767 : 45'sd0);

	always_ff @(posedge clk) begin
		// s7: partial products
		if (en7) begin
			t_s7   <= in_data.temp;
			off_s7 <= in_data.off;
			pl_s7  <= 44'(in_data.d1) * 44'(sens_lo);
			ph_s7  <= 45'($signed({1'b0, in_data.d1})) * 45'(sens_hi);
		end
		// s8: recombine
		if (en8) begin
			t_s8    <= t_s7;
			off_s8  <= off_s7;
			prod_s8 <= (64'(ph_s7) <<< 20) + 64'($signed({1'b0, pl_s7}));
		end
		// s9: /2^21 toward zero, minus OFF
		if (en9) begin
			t_s9 <= t_s8;
			x_s9 <= 45'(prod_rnd >>> 21) - 45'(off_s8);
		end
		// s10: /2^15 toward zero, output register
		if (en10) begin
			t_s10 <= t_s9;
			p_s10 <= 32'(x_rnd >>> 15);
		end
	end

	assign out_valid = v_s10;
	assign temp_out  = t_s10;
	assign press_out = p_s10;

endmodule

`default_nettype wire

// ===== hw/rtl/baro_pressure_temperature_compensation.sv =====
// Each accepted input beat passes through stages s1 to s10 to its result beat.
// Throughput: one beat per cycle unless out_ch.ready stalls the output; each
// of the 10 pipeline stages loads when empty or when the stage after it moves,
// so bubbles close up under stall. Reset (arst_n low) clears all stage valid
// bits and sets every calibration register and the second-order enable to zero.
`default_nettype none

module baro_pressure_temperature_compensation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	bptc_in_if.sink           in_ch,
	bptc_out_if.source        out_ch
);
	import bptc_pkg::*;

	cal_t   cal_q;
	logic   f_valid, f_ready, s_valid, s_ready;
	first_t f_data;
	press_t s_data;

	// calibration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_C1:    cal_q.c1    <= cfg_data;
				REG_C2:    cal_q.c2    <= cfg_data;
				REG_C3:    cal_q.c3    <= cfg_data;
				REG_C4:    cal_q.c4    <= cfg_data;
				REG_C5:    cal_q.c5    <= cfg_data;
				REG_C6:    cal_q.c6    <= cfg_data;
				REG_SO_EN: cal_q.so_en <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	bptc_first u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal_q),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.d1        (in_ch.raw_pressure),
		.d2        (in_ch.raw_temperature),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	bptc_second u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.so_en     (cal_q.so_en),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.out_data  (s_data)
	);

	bptc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_data   (s_data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.temp_out  (out_ch.temp_centideg),
		.press_out (out_ch.pressure_pa)
	);

endmodule

`default_nettype wire
